/* sv/euler_trs_matrix_builder_macros.svh */
// assertion helpers for the matrix builder
`ifndef EULER_TRS_MATRIX_BUILDER_MACROS_SVH
`define EULER_TRS_MATRIX_BUILDER_MACROS_SVH

// same-cycle implication, checked out of reset
`define ETM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define ETM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/etm_pkg.sv */
`default_nettype none
package etm_pkg;

  localparam int unsigned FULL_TURN          = 23040;
  localparam int unsigned HALF_TURN          = 11520;
  localparam int unsigned QUARTER_TURN       = 5760;
  localparam int unsigned THREE_QUARTER_TURN = 17280;
  localparam longint      CORDIC_GAIN_Q30    = 64'sd652032874;
  localparam int unsigned ZW                 = 26;
  localparam int unsigned IN_W               = 240;
  localparam int unsigned OUT_W              = 384;

  typedef logic signed [15:0] angle_t;
  typedef logic signed [31:0] q16_t;
  typedef logic signed [ZW-1:0] zang_t;

  // atan(2^-i) in degrees * 2^16
  localparam logic [22:0] ATAN_TAB [32] = '{
    23'd2949120, 23'd1740967, 23'd919879, 23'd466945, 23'd234379, 23'd117304,
    23'd58666, 23'd29335, 23'd14668, 23'd7334, 23'd3667, 23'd1833, 23'd917,
    23'd458, 23'd229, 23'd115, 23'd57, 23'd29, 23'd14, 23'd7, 23'd4, 23'd2,
    23'd1, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0, 23'd0
  };

  function automatic zang_t atan_step(input int i);
    zang_t s;
    s = '0;
    if (i < 32) begin
      s = zang_t'({3'b000, ATAN_TAB[i[4:0]]});
    end
    return s;
  endfunction

endpackage
`default_nettype wire

/* sv/etm_cordic_lane.sv */
`default_nettype none
module etm_cordic_lane #(
  parameter int unsigned ITERS = 16,
  parameter int unsigned XW    = 19,
  parameter logic signed [XW-1:0] X_INIT = '0
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire etm_pkg::angle_t      ang,
  output logic signed [XW-1:0]      cos_r,
  output logic signed [XW-1:0]      sin_r
);
  import etm_pkg::*;

  logic [16:0]        wrap;
  logic [14:0]        red;
  logic signed [15:0] fold;
  logic               flip0;
  zang_t              z0;

  logic signed [XW-1:0] x_r    [ITERS+1];
  logic signed [XW-1:0] y_r    [ITERS+1];
  zang_t                z_r    [ITERS+1];
  logic                 flip_r [ITERS+1];

  // bring the angle into [0, 360) then fold into [-90, 90]
  always_comb begin
    wrap = 17'($signed({ang[15], ang}) + 17'sd46080);
    if (wrap >= 17'(3 * FULL_TURN)) begin
      red = 15'(wrap - 17'(3 * FULL_TURN));
    end else if (wrap >= 17'(2 * FULL_TURN)) begin
      red = 15'(wrap - 17'(2 * FULL_TURN));
    end else if (wrap >= 17'(FULL_TURN)) begin
      red = 15'(wrap - 17'(FULL_TURN));
    end else begin
      red = 15'(wrap);
    end
    flip0 = 1'b0;
    if (red >= 15'(THREE_QUARTER_TURN)) begin
      fold = $signed({1'b0, red}) - 16'sd23040;
    end else if (red > 15'(QUARTER_TURN)) begin
      fold  = $signed({1'b0, red}) - 16'sd11520;
      flip0 = 1'b1;
    end else begin
      fold = $signed({1'b0, red});
    end
    z0 = zang_t'(fold) <<< 10;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= X_INIT;
      y_r[0]    <= '0;
      z_r[0]    <= z0;
      flip_r[0] <= flip0;
    end
  end

  for (genvar i = 0; i < ITERS; i++) begin : g_iter
    localparam zang_t STEP = atan_step(i);
    logic signed [XW-1:0] dx, dy;
    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    always_ff @(posedge clk) begin
      if (en) begin
        flip_r[i+1] <= flip_r[i];
        if (!z_r[i][ZW-1]) begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - STEP;
        end else begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + STEP;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= flip_r[ITERS] ? -x_r[ITERS] : x_r[ITERS];
      sin_r <= flip_r[ITERS] ? -y_r[ITERS] : y_r[ITERS];
    end
  end

endmodule
`default_nettype wire

/* sv/etm_scale_lane.sv */
`default_nettype none
module etm_scale_lane #(
  parameter int unsigned EW        = 20,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [EW-1:0] entry,
  input  wire etm_pkg::q16_t        scale,
  output etm_pkg::q16_t             res_r
);
  import etm_pkg::*;

  localparam int unsigned PW = EW + 33;
  localparam logic signed [PW-1:0] RND = PW'(64'd1 << (FRAC_BITS - 1));

  logic signed [PW-1:0] prod_r;
  logic signed [PW-1:0] rnd;
  logic                 fits;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PW'(entry * scale);
    end
  end

  always_comb begin
    rnd  = (prod_r + RND) >>> FRAC_BITS;
    fits = (rnd[PW-1:31] == '0) || (rnd[PW-1:31] == '1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (fits) begin
        res_r <= rnd[31:0];
      end else if (rnd[PW-1]) begin
        res_r <= 32'sh8000_0000;
      end else begin
        res_r <= 32'sh7fff_ffff;
      end
    end
  end

endmodule
`default_nettype wire

/* sv/euler_trs_matrix_builder.sv */
`default_nettype none
// Builds rows 0..2 of T*Rz*Ry*Rx*S from a position, three angles (1/64 degree) and
// three scales, all Q16.16 on the output, the scaled entries with saturation; row 3 is always 0 0 0 1.
// One request is taken every cycle unless the pipeline stalls; a result passes through
// angle reduction, the unrolled CORDIC pipeline (one stage per iteration), the sign
// restore stage, two product stages and the scale multiply and saturate stages. The
// whole pipeline stalls only while a result waits on out_tready.
module euler_trs_matrix_builder #(
  parameter int unsigned TRIG_ITERATIONS = 16,
  parameter int unsigned FRAC_BITS       = 16
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // pos_x, pos_y, pos_z, rot_x_deg, rot_y_deg, rot_z_deg, scale_x, scale_y, scale_z
  input  wire logic [etm_pkg::IN_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // row0_col0..row0_col3, row1_col0..row1_col3, row2_col0..row2_col3
  output logic [etm_pkg::OUT_W-1:0]       out_tdata
);
  import etm_pkg::*;

  `include "euler_trs_matrix_builder_macros.svh"

  localparam int unsigned XW    = FRAC_BITS + 3;
  localparam int unsigned EW    = XW + 1;
  localparam int unsigned DEPTH = TRIG_ITERATIONS + 6;
  localparam int unsigned K_MUL = TRIG_ITERATIONS + 3;
  localparam longint X0 = (CORDIC_GAIN_Q30 + (64'sd1 <<< (29 - FRAC_BITS)))
                          >>> (30 - FRAC_BITS);
  localparam logic signed [XW-1:0] X_INIT = XW'(X0);
  localparam logic signed [2*XW-1:0] QRND = (2*XW)'(64'd1 << (FRAC_BITS - 1));

  function automatic logic signed [XW-1:0] qmul(input logic signed [XW-1:0] a,
                                                 input logic signed [XW-1:0] b);
    logic signed [2*XW-1:0] p;
    p = a * b;
    p = (p + QRND) >>> FRAC_BITS;
    return p[XW-1:0];
  endfunction

  logic en;
  logic vld_r [DEPTH];
  logic [191:0] pl_r [DEPTH];

  assign en         = !out_tvalid || out_tready;
  assign in_tready  = en;
  assign out_tvalid = vld_r[DEPTH-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < DEPTH; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= in_tvalid;
      for (int k = 1; k < DEPTH; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // position and scales ride along with the angles
  always_ff @(posedge clk) begin
    if (en) begin
      pl_r[0] <= {in_tdata[239:144], in_tdata[95:0]};
      for (int k = 1; k < DEPTH; k++) begin
        pl_r[k] <= pl_r[k-1];
      end
    end
  end

  logic signed [XW-1:0] cx, sx, cy, sy, cz, sz;

  etm_cordic_lane #(.ITERS(TRIG_ITERATIONS), .XW(XW), .X_INIT(X_INIT)) u_lane_x (
    .clk(clk), .en(en), .ang(in_tdata[111:96]), .cos_r(cx), .sin_r(sx));
  etm_cordic_lane #(.ITERS(TRIG_ITERATIONS), .XW(XW), .X_INIT(X_INIT)) u_lane_y (
    .clk(clk), .en(en), .ang(in_tdata[127:112]), .cos_r(cy), .sin_r(sy));
  etm_cordic_lane #(.ITERS(TRIG_ITERATIONS), .XW(XW), .X_INIT(X_INIT)) u_lane_z (
    .clk(clk), .en(en), .ang(in_tdata[143:128]), .cos_r(cz), .sin_r(sz));

  logic signed [XW-1:0] czsy_r, szsy_r, czcy_r, szcy_r, cysx_r, cycx_r;
  logic signed [XW-1:0] szcx_r, szsx_r, czcx_r, czsx_r, sx_r, cx_r;
  logic signed [EW-1:0] nsy_r;
  logic signed [EW-1:0] ent_r [9];

  always_ff @(posedge clk) begin
    if (en) begin
      czsy_r <= qmul(cz, sy);
      szsy_r <= qmul(sz, sy);
      czcy_r <= qmul(cz, cy);
      szcy_r <= qmul(sz, cy);
      cysx_r <= qmul(cy, sx);
      cycx_r <= qmul(cy, cx);
      szcx_r <= qmul(sz, cx);
      szsx_r <= qmul(sz, sx);
      czcx_r <= qmul(cz, cx);
      czsx_r <= qmul(cz, sx);
      sx_r   <= sx;
      cx_r   <= cx;
      nsy_r  <= -EW'(sy);
    end
  end

  // merge the lane results into the nine rotation entries
  always_ff @(posedge clk) begin
    if (en) begin
      ent_r[0] <= EW'(czcy_r);
      ent_r[1] <= EW'(qmul(czsy_r, sx_r)) - EW'(szcx_r);
      ent_r[2] <= EW'(qmul(czsy_r, cx_r)) + EW'(szsx_r);
      ent_r[3] <= EW'(szcy_r);
      ent_r[4] <= EW'(qmul(szsy_r, sx_r)) + EW'(czcx_r);
      ent_r[5] <= EW'(qmul(szsy_r, cx_r)) - EW'(czsx_r);
      ent_r[6] <= nsy_r;
      ent_r[7] <= EW'(cysx_r);
      ent_r[8] <= EW'(cycx_r);
    end
  end

  q16_t res [9];

  for (genvar e = 0; e < 9; e++) begin : g_scale
    etm_scale_lane #(.EW(EW), .FRAC_BITS(FRAC_BITS)) u_scale (
      .clk(clk), .en(en), .entry(ent_r[e]),
      .scale(pl_r[K_MUL][96 + 32*(e % 3) +: 32]), .res_r(res[e]));
  end

  assign out_tdata = {pl_r[DEPTH-1][95:64], res[8], res[7], res[6],
                      pl_r[DEPTH-1][63:32], res[5], res[4], res[3],
                      pl_r[DEPTH-1][31:0],  res[2], res[1], res[0]};

  `ETM_ASSERT_NOW(a_empty_ready, !out_tvalid, in_tready, "empty output blocks input")
  `ETM_ASSERT_NEXT(a_last_stage, vld_r[DEPTH-2] && in_tready, out_tvalid,
                   "pipeline item lost before output")
  `ETM_ASSERT_NEXT(a_drain, !vld_r[DEPTH-2] && out_tvalid && out_tready, !out_tvalid,
                   "result repeated after delivery")

endmodule
`default_nettype wire
